[rtl/fcbg_pkg.sv]
// Shared types and constants of the floppy card bus glue.
`timescale 1ns / 1ps
`default_nettype none
package fcbg_pkg;

    localparam int RAM_BYTES = 2048;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam int ADDR_W  = 21;
    localparam int COUNT_W = 13;
    localparam int DEV_W   = 15;

    localparam logic [COUNT_W-1:0] MOTOR_TICKS_RESET = 13'd4230;

    localparam logic [ADDR_W-1:0] CTL_BASE      = 21'h001100;
    localparam logic [12:0]       CTL_PAGE      = CTL_BASE[20:8];
    localparam logic [ADDR_W-1:0] MAP_MASK_STD  = 21'h07e000;
    localparam logic [ADDR_W-1:0] MAP_VAL_STD   = 21'h074000;
    localparam logic [ADDR_W-1:0] MAP_MASK_EXT  = 21'h1fe000;
    localparam logic [ADDR_W-1:0] MAP_VAL_EXT   = 21'h174000;
    localparam logic [ADDR_W-1:0] TOP_MASK      = 21'h001c00;
    localparam logic [ADDR_W-1:0] CLK_MASK      = 21'h0003e1;
    localparam logic [ADDR_W-1:0] CLK_VAL       = 21'h0003e0;
    localparam logic [ADDR_W-1:0] CTRL_MASK     = 21'h0003f9;
    localparam logic [ADDR_W-1:0] CTRL_RD_VAL   = 21'h0003f0;
    localparam logic [ADDR_W-1:0] CTRL_WR_VAL   = 21'h0003f8;

    localparam logic [3:0] CB_SELECT  = 4'd0;
    localparam logic [3:0] CB_MOTOR   = 4'd1;
    localparam logic [3:0] CB_HOLD    = 4'd2;
    localparam logic [3:0] CB_DRV0    = 4'd4;
    localparam logic [3:0] CB_DRV1    = 4'd5;
    localparam logic [3:0] CB_DRV2    = 4'd6;
    localparam logic [3:0] CB_SIDE    = 4'd7;
    localparam logic [3:0] CB_DRV3    = 4'd8;
    localparam logic [3:0] CB_DENSITY = 4'd10;
    localparam logic [3:0] CB_ROM0    = 4'd11;
    localparam logic [3:0] CB_RAM     = 4'd13;
    localparam logic [3:0] CB_CLOCK   = 4'd14;
    localparam logic [3:0] CB_ROM1    = 4'd15;

    localparam logic [2:0] CFG_DIP_ONE        = 3'd0;
    localparam logic [2:0] CFG_DIP_TWO        = 3'd1;
    localparam logic [2:0] CFG_DIP_THREE_FOUR = 3'd2;
    localparam logic [2:0] CFG_EXTENDED_MAP   = 3'd3;
    localparam logic [2:0] CFG_MOTOR_TICKS    = 3'd4;

    typedef enum logic [2:0] {
        OP_MEM_RD  = 3'd0,
        OP_MEM_WR  = 3'd1,
        OP_CTL_RD  = 3'd2,
        OP_CTL_WR  = 3'd3,
        OP_TICK    = 3'd4,
        OP_IRQ     = 3'd5,
        OP_DRQ     = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_RAM    = 3'd2,
        TGT_CTRL   = 3'd3,
        TGT_CLOCK  = 3'd4,
        TGT_REPLY  = 3'd5
    } target_t;

    typedef struct packed {
        logic             interrupt_b;
        logic             cpu_halt;
        logic             motor_enable;
        logic             density_line;
        logic             side_select;
        logic [1:0]       drive_number;
        logic             drive_strobe;
        logic [7:0]       device_data;
        logic             device_write;
        logic [DEV_W-1:0] device_address;
        target_t          target;
        logic [7:0]       read_data;
    } result_t;

endpackage
`default_nettype wire

[rtl/fcbg_ram.sv]
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fcbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/floppy_card_bus_glue.sv]
// Top level of the floppy card bus glue: decode, card latches, buffer RAM.
//
// Takes one item per cycle while s_axis_tready is high and returns one result
// item for each through a stage that waits for the RAM read and a result
// register; the input stays open while a result waits downstream if that
// stage is empty. All card state sits in flip-flops except the 2 KiB buffer,
// a single-port RAM with registered read that serves one read or one write
// per item. After reset the buffer is swept to zero, one byte a cycle, and
// s_axis_tready is low during it; configuration writes are taken as usual.
`timescale 1ns / 1ps
`default_nettype none
module floppy_card_bus_glue
    import fcbg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[2:0], bus_address[23:3], write_data[31:24], line_level[32]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0], target[10:8], device_address[25:11], device_write[26],
    // device_data[34:27], drive_strobe[35], drive_number[37:36],
    // side_select[38], density_line[39], motor_enable[40], cpu_halt[41],
    // interrupt_b[42]
    output logic [47:0]      m_axis_tdata
);

    logic               dip_one_reg;
    logic               dip_two_reg;
    logic [1:0]         dip_three_four_reg;
    logic               extended_map_reg;
    logic [COUNT_W-1:0] motor_ticks_reg;

    logic               card_selected_reg, card_selected_next;
    logic               motor_strobe_last_reg, motor_strobe_last_next;
    logic               motor_on_reg, motor_on_next;
    logic [COUNT_W-1:0] motor_count_reg, motor_count_next;
    logic               hold_enable_reg, hold_enable_next;
    logic [3:0]         drive_mask_reg, drive_mask_next;
    logic               side_latch_reg, side_latch_next;
    logic               density_latch_reg, density_latch_next;
    logic [1:0]         rom_bank_reg, rom_bank_next;
    logic               ram_bank_reg, ram_bank_next;
    logic               clock_overlay_reg, clock_overlay_next;
    logic               irq_level_reg, irq_level_next;
    logic               drq_level_reg, drq_level_next;

    logic               clr_active_reg;
    logic [RAM_AW-1:0]  clr_addr_reg;

    logic               s1_valid_reg;
    logic               s1_ram_rd_reg;
    result_t            s1_res_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;

    op_t                op;
    logic [ADDR_W-1:0]  a;
    logic [7:0]         d;
    logic               lvl;
    logic               in_accept;
    logic               s1_move;

    result_t            res;
    result_t            out_res_next;
    logic               ram_rd;
    logic               ram_wr;
    logic               ram_en;
    logic               ram_we;
    logic [RAM_AW-1:0]  ram_addr;
    logic [RAM_AW-1:0]  ram_idx;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_q;

    logic [ADDR_W-1:0]  map_mask;
    logic [ADDR_W-1:0]  map_val;
    logic               win_hit;
    logic               is_wr;
    logic [3:0]         cbit;
    logic               cset;
    logic [1:0]         drv;
    logic [3:0]         drv_onehot;

    assign op  = op_t'(s_axis_tdata[2:0]);
    assign a   = s_axis_tdata[23:3];
    assign d   = s_axis_tdata[31:24];
    assign lvl = s_axis_tdata[32];

    assign s1_move       = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = ~clr_active_reg & (~s1_valid_reg | s1_move);
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign map_mask   = extended_map_reg ? MAP_MASK_EXT : MAP_MASK_STD;
    assign map_val    = extended_map_reg ? MAP_VAL_EXT : MAP_VAL_STD;
    assign win_hit    = card_selected_reg & ((a & map_mask) == map_val);
    assign is_wr      = (op == OP_MEM_WR);
    assign cbit       = a[4:1];
    assign cset       = |d;
    assign drv        = (cbit == CB_DRV3) ? 2'd3 : cbit[1:0];
    assign drv_onehot = 4'b0001 << drv;
    assign ram_idx    = {ram_bank_reg, a[RAM_AW-2:0]};

    always_comb
    begin
        card_selected_next     = card_selected_reg;
        motor_strobe_last_next = motor_strobe_last_reg;
        motor_on_next          = motor_on_reg;
        motor_count_next       = motor_count_reg;
        hold_enable_next       = hold_enable_reg;
        drive_mask_next        = drive_mask_reg;
        side_latch_next        = side_latch_reg;
        density_latch_next     = density_latch_reg;
        rom_bank_next          = rom_bank_reg;
        ram_bank_next          = ram_bank_reg;
        clock_overlay_next     = clock_overlay_reg;
        irq_level_next         = irq_level_reg;
        drq_level_next         = drq_level_reg;
        res                    = '0;
        ram_rd                 = 1'b0;
        ram_wr                 = 1'b0;

        if (in_accept)
        begin
            case (op)
                OP_MEM_RD, OP_MEM_WR:
                begin
                    if (win_hit)
                    begin
                        if ((a & TOP_MASK) != TOP_MASK)
                        begin
                            if (!is_wr)
                            begin
                                res.target         = TGT_ROM;
                                res.device_address = {rom_bank_reg, a[12:0]};
                            end
                        end
                        else if (clock_overlay_reg && ((a & CLK_MASK) == CLK_VAL))
                        begin
                            res.target         = TGT_CLOCK;
                            res.device_address = {11'd0, a[4:1]};
                            res.device_write   = is_wr;
                            res.device_data    = is_wr ? d : 8'd0;
                        end
                        else if (!clock_overlay_reg && ((a & CTRL_MASK) ==
                                 (is_wr ? CTRL_WR_VAL : CTRL_RD_VAL)))
                        begin
                            res.target         = TGT_CTRL;
                            res.device_address = {13'd0, a[2:1]};
                            res.device_write   = is_wr;
                            res.device_data    = is_wr ? d : 8'd0;
                        end
                        else
                        begin
                            res.target         = TGT_RAM;
                            res.device_address = {{(DEV_W-RAM_AW){1'b0}}, ram_idx};
                            res.device_write   = is_wr;
                            ram_wr             = is_wr;
                            ram_rd             = ~is_wr;
                        end
                    end
                end
                OP_CTL_RD:
                begin
                    if (a[20:8] == CTL_PAGE)
                    begin
                        res.target = TGT_REPLY;
                        if (a[7:0] == 8'd0)
                        begin
                            res.read_data = ~{dip_three_four_reg, dip_two_reg,
                                              dip_one_reg, 4'd0};
                        end
                    end
                end
                OP_CTL_WR:
                begin
                    if (a[20:8] == CTL_PAGE)
                    begin
                        case (cbit)
                            CB_SELECT:  card_selected_next = cset;
                            CB_MOTOR:
                            begin
                                if (cset && !motor_strobe_last_reg)
                                begin
                                    motor_on_next    = 1'b1;
                                    motor_count_next = motor_ticks_reg;
                                end
                                motor_strobe_last_next = cset;
                            end
                            CB_HOLD:    hold_enable_next = cset;
                            CB_DRV0, CB_DRV1, CB_DRV2, CB_DRV3:
                            begin
                                if (cset)
                                begin
                                    if ((drive_mask_reg & drv_onehot) == 4'd0)
                                    begin
                                        drive_mask_next  = drive_mask_reg | drv_onehot;
                                        res.drive_strobe = 1'b1;
                                        res.drive_number = drv;
                                    end
                                end
                                else
                                begin
                                    drive_mask_next = drive_mask_reg & ~drv_onehot;
                                end
                            end
                            CB_SIDE:    side_latch_next    = cset;
                            CB_DENSITY: density_latch_next = cset;
                            CB_ROM0:    rom_bank_next      = {rom_bank_reg[1], cset};
                            CB_RAM:     ram_bank_next      = cset;
                            CB_CLOCK:   clock_overlay_next = cset;
                            CB_ROM1:    rom_bank_next      = {cset, rom_bank_reg[0]};
                            default:    ;
                        endcase
                    end
                end
                OP_TICK:
                begin
                    if (motor_on_reg)
                    begin
                        if (motor_count_reg <= 13'd1)
                        begin
                            motor_count_next = '0;
                            motor_on_next    = 1'b0;
                        end
                        else
                        begin
                            motor_count_next = motor_count_reg - 13'd1;
                        end
                    end
                end
                OP_IRQ:  irq_level_next = lvl;
                OP_DRQ:  drq_level_next = lvl;
                default: ;
            endcase
        end

        res.side_select  = side_latch_next;
        res.density_line = density_latch_next;
        res.motor_enable = motor_on_next;
        res.cpu_halt     = hold_enable_next & motor_on_next & ~irq_level_next
                           & ~drq_level_next;
        res.interrupt_b  = irq_level_next;
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_en    = ram_rd | ram_wr;
            ram_we    = ram_wr;
            ram_addr  = ram_idx;
            ram_wdata = d;
        end
    end

    always_comb
    begin
        out_res_next = s1_res_reg;
        if (s1_ram_rd_reg)
        begin
            out_res_next.read_data = ram_q;
        end
    end

    fcbg_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_buffer_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_one_reg           <= 1'b0;
            dip_two_reg           <= 1'b0;
            dip_three_four_reg    <= 2'd0;
            extended_map_reg      <= 1'b0;
            motor_ticks_reg       <= MOTOR_TICKS_RESET;
            card_selected_reg     <= 1'b0;
            motor_strobe_last_reg <= 1'b0;
            motor_on_reg          <= 1'b0;
            motor_count_reg       <= '0;
            hold_enable_reg       <= 1'b0;
            drive_mask_reg        <= 4'd0;
            side_latch_reg        <= 1'b0;
            density_latch_reg     <= 1'b0;
            rom_bank_reg          <= 2'd0;
            ram_bank_reg          <= 1'b0;
            clock_overlay_reg     <= 1'b0;
            irq_level_reg         <= 1'b0;
            drq_level_reg         <= 1'b0;
            clr_active_reg        <= 1'b1;
            clr_addr_reg          <= '0;
            s1_valid_reg          <= 1'b0;
            s1_ram_rd_reg         <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIP_ONE:        dip_one_reg        <= cfg_data[0];
                    CFG_DIP_TWO:        dip_two_reg        <= cfg_data[0];
                    CFG_DIP_THREE_FOUR: dip_three_four_reg <= cfg_data[1:0];
                    CFG_EXTENDED_MAP:   extended_map_reg   <= cfg_data[0];
                    CFG_MOTOR_TICKS:    motor_ticks_reg    <= cfg_data;
                    default:            ;
                endcase
            end

            card_selected_reg     <= card_selected_next;
            motor_strobe_last_reg <= motor_strobe_last_next;
            motor_on_reg          <= motor_on_next;
            motor_count_reg       <= motor_count_next;
            hold_enable_reg       <= hold_enable_next;
            drive_mask_reg        <= drive_mask_next;
            side_latch_reg        <= side_latch_next;
            density_latch_reg     <= density_latch_next;
            rom_bank_reg          <= rom_bank_next;
            ram_bank_reg          <= ram_bank_next;
            clock_overlay_reg     <= clock_overlay_next;
            irq_level_reg         <= irq_level_next;
            drq_level_reg         <= drq_level_next;

            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {RAM_AW{1'b1}})
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (in_accept)
            begin
                s1_valid_reg  <= 1'b1;
                s1_ram_rd_reg <= ram_rd;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg};

endmodule
`default_nettype wire
